/* rtl/bbd_pkg.sv */
package bbd_pkg;

  localparam int MAX_DEGREE_DEF = 3;
  localparam int KNOT_DEPTH_DEF = 64;

  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

  // widths of the micro-op fields, sized for the largest build
  localparam int UA_W   = 8;
  localparam int UK_W   = 10;
  localparam int FACT_W = 6;

  // configuration register indexes
  localparam logic [0:0] CFG_DEGREE = 1'd0;
  localparam logic [0:0] CFG_ZTHR   = 1'd1;

  // request operations
  localparam logic OPN_WRITE = 1'b0;
  localparam logic OPN_EVAL  = 1'b1;

  // shared unit operations
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MULQ = 3'd2;
  localparam logic [2:0] OP_MULI = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;

  // operand sources
  localparam logic [2:0] SRC_ZERO = 3'd0;
  localparam logic [2:0] SRC_ONE  = 3'd1;
  localparam logic [2:0] SRC_REG  = 3'd2;
  localparam logic [2:0] SRC_KNOT = 3'd3;
  localparam logic [2:0] SRC_U    = 3'd4;
  localparam logic [2:0] SRC_FACT = 3'd5;

  typedef struct packed {
    logic              operation;
    logic [5:0]        index;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         basis_index;
    logic signed [31:0] basis_value;
    logic signed [31:0] first_derivative;
    logic signed [31:0] second_derivative;
    logic               span_error;
    logic               last;
  } out_res_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [2:0]        a_src;
    logic [UA_W-1:0]   a_addr;
    logic [2:0]        b_src;
    logic [UA_W-1:0]   b_addr;
    logic [UA_W-1:0]   dst;
    logic [UK_W-1:0]   kaddr;
    logic [FACT_W-1:0] fact;
  } uop_t;

  function automatic logic signed [31:0] sat64(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (x < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return x[31:0];
  endfunction

endpackage

/* rtl/bbd_div.sv */
module bbd_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  input  logic [15:0]        thr,
  output logic               done,
  output logic signed [31:0] quo
);
  import bbd_pkg::*;

  localparam logic [1:0] DS_IDLE = 2'd0;
  localparam logic [1:0] DS_RUN  = 2'd1;
  localparam logic [1:0] DS_FIN  = 2'd2;

  logic [1:0]  st_r, st_nxt;
  logic [5:0]  cnt_r;
  logic [47:0] dvd_r;
  logic [32:0] rem_r;
  logic [31:0] ad_r;
  logic        neg_r;
  logic        zero_r;
  logic        done_r;
  logic signed [31:0] quo_r;

  logic [31:0] an, ad;
  logic [32:0] rem_sh;
  logic        qbit;
  logic signed [63:0] qs;

  assign an = num[31] ? 32'(-{1'b0, num}) : 32'(num);
  assign ad = den[31] ? 32'(-{1'b0, den}) : 32'(den);
  assign rem_sh = {rem_r[31:0], dvd_r[47]};
  assign qbit = rem_sh >= {1'b0, ad_r};
  assign qs = neg_r ? -$signed({16'd0, dvd_r}) : $signed({16'd0, dvd_r});

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      DS_IDLE: if (start) st_nxt = DS_RUN;
      DS_RUN:  if (zero_r || cnt_r == 6'd47) st_nxt = DS_FIN;
      DS_FIN:  st_nxt = DS_IDLE;
      default: st_nxt = DS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= DS_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == DS_FIN);
    end
    case (st_r)
      DS_IDLE: begin
        // rounding term folded into the dividend
        dvd_r  <= {an, 16'd0} + 48'(ad >> 1);
        rem_r  <= '0;
        ad_r   <= ad;
        neg_r  <= num[31] != den[31];
        zero_r <= ad <= 32'(thr);
        cnt_r  <= '0;
      end
      DS_RUN: begin
        rem_r <= qbit ? rem_sh - {1'b0, ad_r} : rem_sh;
        dvd_r <= {dvd_r[46:0], qbit};
        cnt_r <= cnt_r + 6'd1;
      end
      DS_FIN: quo_r <= zero_r ? 32'sd0 : sat64(qs);
      default: ;
    endcase
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

/* rtl/bbd_mul.sv */
module bbd_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               frac,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic               done,
  output logic signed [31:0] res
);
  import bbd_pkg::*;

  logic               v1_r, done_r, frac_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] res_r;
  logic [63:0]        pmag, rnd;
  logic signed [63:0] qv;

  // round to nearest, ties away from zero
  assign pmag = prod_r[63] ? 64'(-prod_r) : 64'(prod_r);
  assign rnd  = (pmag + 64'd32768) >> 16;
  assign qv   = prod_r[63] ? -$signed(rnd) : $signed(rnd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      done_r <= v1_r;
    end
    prod_r <= a * b;
    frac_r <= frac;
    res_r  <= frac_r ? sat64(qv) : sat64(prod_r);
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

/* rtl/bbd_seq.sv */
module bbd_seq #(
  parameter int MAX_DEGREE = bbd_pkg::MAX_DEGREE_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  go,
  input  logic [$clog2(MAX_DEGREE+1)-1:0]       p_in,
  input  logic [5:0]                            span_in,
  input  logic                                  adv,
  output bbd_pkg::uop_t                         uop,
  output logic                                  done
);
  import bbd_pkg::*;

  localparam int DIM     = MAX_DEGREE + 2;
  localparam int LEFT_B  = DIM * DIM;
  localparam int RIGHT_B = LEFT_B + DIM;
  localparam int A0_B    = RIGHT_B + DIM;
  localparam int A1_B    = A0_B + DIM;
  localparam int D1_B    = A1_B + DIM;
  localparam int D2_B    = D1_B + DIM;
  localparam int T_A     = D2_B + DIM;
  localparam int SV_A    = T_A + 1;
  localparam int TMP_A   = T_A + 2;
  localparam int M_A     = T_A + 3;
  localparam int CW      = $clog2(MAX_DEGREE + 2);
  localparam int PW      = $clog2(MAX_DEGREE + 1);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_INIT = 5'd1;
  localparam logic [4:0] V_L     = 5'd2;
  localparam logic [4:0] V_R     = 5'd3;
  localparam logic [4:0] V_S0    = 5'd4;
  localparam logic [4:0] V_N     = 5'd5;
  localparam logic [4:0] V_D     = 5'd6;
  localparam logic [4:0] V_M1    = 5'd7;
  localparam logic [4:0] V_A     = 5'd8;
  localparam logic [4:0] V_M2    = 5'd9;
  localparam logic [4:0] V_E     = 5'd10;
  localparam logic [4:0] D_A0    = 5'd11;
  localparam logic [4:0] D_Z     = 5'd12;
  localparam logic [4:0] D_F0    = 5'd13;
  localparam logic [4:0] D_F1    = 5'd14;
  localparam logic [4:0] D_F2    = 5'd15;
  localparam logic [4:0] D_J0    = 5'd16;
  localparam logic [4:0] D_J1    = 5'd17;
  localparam logic [4:0] D_J2    = 5'd18;
  localparam logic [4:0] D_J3    = 5'd19;
  localparam logic [4:0] D_T0    = 5'd20;
  localparam logic [4:0] D_T1    = 5'd21;
  localparam logic [4:0] D_T2    = 5'd22;
  localparam logic [4:0] D_T3    = 5'd23;
  localparam logic [4:0] S_SC    = 5'd24;

  logic [4:0]    st_r, st_nxt;
  logic [CW-1:0] j_r, j_nxt, r_r, r_nxt, jj_r, jj_nxt;
  logic [1:0]    k_r, k_nxt;
  logic [PW-1:0] p_r;
  logic [5:0]    span_r;

  function automatic logic [UA_W-1:0] ua(input int x);
    return UA_W'(x);
  endfunction

  function automatic logic [UA_W-1:0] nd(input int i, input int c);
    return UA_W'(i * DIM + c);
  endfunction

  int j, r, k, jj, p, rk, pk, sb, db, acc, j1, j2;

  always_comb begin
    j   = int'(j_r);
    r   = int'(r_r);
    k   = int'(k_r);
    jj  = int'(jj_r);
    p   = int'(p_r);
    rk  = r - k;
    pk  = p - k;
    sb  = (k == 1) ? A0_B : A1_B;
    db  = (k == 1) ? A1_B : A0_B;
    acc = ((k == 1) ? D1_B : D2_B) + r;
    j1  = (rk >= -1) ? 1 : -rk;
    j2  = (r - 1 <= pk) ? (k - 1) : (p - r);
  end

  always_comb begin
    uop        = '0;
    uop.op     = OP_ADD;
    uop.a_src  = SRC_ZERO;
    uop.b_src  = SRC_ZERO;
    uop.fact   = (k == 1) ? FACT_W'(p) : FACT_W'(p * (p - 1));
    case (st_r)
      ST_INIT: begin
        uop.a_src = SRC_ONE;
        uop.dst   = nd(0, 0);
      end
      V_L: begin
        uop.op    = OP_SUB;
        uop.a_src = SRC_U;
        uop.b_src = SRC_KNOT;
        uop.kaddr = UK_W'(int'(span_r) + 1 - j);
        uop.dst   = ua(LEFT_B + j);
      end
      V_R: begin
        uop.op    = OP_SUB;
        uop.a_src = SRC_KNOT;
        uop.b_src = SRC_U;
        uop.kaddr = UK_W'(int'(span_r) + j);
        uop.dst   = ua(RIGHT_B + j);
      end
      V_S0: uop.dst = ua(SV_A);
      V_N: begin
        uop.a_src  = SRC_REG;
        uop.a_addr = ua(RIGHT_B + r + 1);
        uop.b_src  = SRC_REG;
        uop.b_addr = ua(LEFT_B + j - r);
        uop.dst    = nd(j, r);
      end
      V_D: begin
        uop.op     = OP_DIV;
        uop.a_src  = SRC_REG;
        uop.a_addr = nd(r, j - 1);
        uop.b_src  = SRC_REG;
        uop.b_addr = nd(j, r);
        uop.dst    = ua(T_A);
      end
      V_M1: begin
        uop.op     = OP_MULQ;
        uop.a_src  = SRC_REG;
        uop.a_addr = ua(RIGHT_B + r + 1);
        uop.b_src  = SRC_REG;
        uop.b_addr = ua(T_A);
        uop.dst    = ua(M_A);
      end
      V_A: begin
        uop.a_src  = SRC_REG;
        uop.a_addr = ua(SV_A);
        uop.b_src  = SRC_REG;
        uop.b_addr = ua(M_A);
        uop.dst    = nd(r, j);
      end
      V_M2: begin
        uop.op     = OP_MULQ;
        uop.a_src  = SRC_REG;
        uop.a_addr = ua(LEFT_B + j - r);
        uop.b_src  = SRC_REG;
        uop.b_addr = ua(T_A);
        uop.dst    = ua(SV_A);
      end
      V_E: begin
        uop.a_src  = SRC_REG;
        uop.a_addr = ua(SV_A);
        uop.dst    = nd(j, j);
      end
      D_A0: begin
        uop.a_src = SRC_ONE;
        uop.dst   = ua(A0_B);
      end
      D_Z: uop.dst = ua(acc);
      D_F0: begin
        uop.op     = OP_DIV;
        uop.a_src  = SRC_REG;
        uop.a_addr = ua(sb);
        uop.b_src  = SRC_REG;
        uop.b_addr = nd(pk + 1, rk);
        uop.dst    = ua(db);
      end
      D_F1: begin
        uop.op     = OP_MULQ;
        uop.a_src  = SRC_REG;
        uop.a_addr = ua(db);
        uop.b_src  = SRC_REG;
        uop.b_addr = nd(rk, pk);
        uop.dst    = ua(M_A);
      end
      D_F2, D_J3, D_T3: begin
        uop.a_src  = SRC_REG;
        uop.a_addr = ua(acc);
        uop.b_src  = SRC_REG;
        uop.b_addr = ua(M_A);
        uop.dst    = ua(acc);
      end
      D_J0: begin
        uop.op     = OP_SUB;
        uop.a_src  = SRC_REG;
        uop.a_addr = ua(sb + jj);
        uop.b_src  = SRC_REG;
        uop.b_addr = ua(sb + jj - 1);
        uop.dst    = ua(TMP_A);
      end
      D_J1: begin
        uop.op     = OP_DIV;
        uop.a_src  = SRC_REG;
        uop.a_addr = ua(TMP_A);
        uop.b_src  = SRC_REG;
        uop.b_addr = nd(pk + 1, rk + jj);
        uop.dst    = ua(db + jj);
      end
      D_J2: begin
        uop.op     = OP_MULQ;
        uop.a_src  = SRC_REG;
        uop.a_addr = ua(db + jj);
        uop.b_src  = SRC_REG;
        uop.b_addr = nd(rk + jj, pk);
        uop.dst    = ua(M_A);
      end
      D_T0: begin
        uop.op     = OP_SUB;
        uop.b_src  = SRC_REG;
        uop.b_addr = ua(sb + k - 1);
        uop.dst    = ua(TMP_A);
      end
      D_T1: begin
        uop.op     = OP_DIV;
        uop.a_src  = SRC_REG;
        uop.a_addr = ua(TMP_A);
        uop.b_src  = SRC_REG;
        uop.b_addr = nd(pk + 1, r);
        uop.dst    = ua(db + k);
      end
      D_T2: begin
        uop.op     = OP_MULQ;
        uop.a_src  = SRC_REG;
        uop.a_addr = ua(db + k);
        uop.b_src  = SRC_REG;
        uop.b_addr = nd(r, pk);
        uop.dst    = ua(M_A);
      end
      S_SC: begin
        uop.op     = OP_MULI;
        uop.a_src  = SRC_REG;
        uop.a_addr = ua(((k == 1) ? D1_B : D2_B) + jj);
        uop.b_src  = SRC_FACT;
        uop.dst    = ua(((k == 1) ? D1_B : D2_B) + jj);
      end
      default: ;
    endcase
  end

  logic do_j, do_tail, do_end;

  always_comb begin
    st_nxt  = st_r;
    j_nxt   = j_r;
    r_nxt   = r_r;
    k_nxt   = k_r;
    jj_nxt  = jj_r;
    do_j    = 1'b0;
    do_tail = 1'b0;
    do_end  = 1'b0;
    if (go) begin
      st_nxt = ST_INIT;
    end else if (adv) begin
      case (st_r)
        ST_INIT: begin
          if (p >= 1) begin
            j_nxt  = CW'(1);
            st_nxt = V_L;
          end else begin
            r_nxt  = '0;
            st_nxt = D_A0;
          end
        end
        V_L:  st_nxt = V_R;
        V_R: begin
          r_nxt  = '0;
          st_nxt = V_S0;
        end
        V_S0: st_nxt = V_N;
        V_N:  st_nxt = V_D;
        V_D:  st_nxt = V_M1;
        V_M1: st_nxt = V_A;
        V_A:  st_nxt = V_M2;
        V_M2: begin
          if (r + 1 < j) begin
            r_nxt  = CW'(r + 1);
            st_nxt = V_N;
          end else begin
            st_nxt = V_E;
          end
        end
        V_E: begin
          if (j < p) begin
            j_nxt  = CW'(j + 1);
            st_nxt = V_L;
          end else begin
            r_nxt  = '0;
            st_nxt = D_A0;
          end
        end
        D_A0: begin
          k_nxt  = 2'd1;
          st_nxt = D_Z;
        end
        D_Z: begin
          if (r >= k) st_nxt = D_F0;
          else do_j = 1'b1;
        end
        D_F0: st_nxt = D_F1;
        D_F1: st_nxt = D_F2;
        D_F2: do_j = 1'b1;
        D_J0: st_nxt = D_J1;
        D_J1: st_nxt = D_J2;
        D_J2: st_nxt = D_J3;
        D_J3: begin
          if (jj + 1 <= j2) begin
            jj_nxt = CW'(jj + 1);
            st_nxt = D_J0;
          end else begin
            do_tail = 1'b1;
          end
        end
        D_T0: st_nxt = D_T1;
        D_T1: st_nxt = D_T2;
        D_T2: st_nxt = D_T3;
        D_T3: do_end = 1'b1;
        S_SC: begin
          if (jj < p) begin
            jj_nxt = CW'(jj + 1);
          end else if (k == 1) begin
            k_nxt  = 2'd2;
            jj_nxt = '0;
          end else begin
            st_nxt = ST_IDLE;
          end
        end
        default: st_nxt = ST_IDLE;
      endcase
      if (do_j) begin
        if (j1 <= j2) begin
          jj_nxt = CW'(j1);
          st_nxt = D_J0;
        end else begin
          do_tail = 1'b1;
        end
      end
      if (do_tail) begin
        if (r <= pk) st_nxt = D_T0;
        else do_end = 1'b1;
      end
      if (do_end) begin
        if (k == 1) begin
          k_nxt  = 2'd2;
          st_nxt = D_Z;
        end else if (r < p) begin
          r_nxt  = CW'(r + 1);
          st_nxt = D_A0;
        end else begin
          k_nxt  = 2'd1;
          jj_nxt = '0;
          st_nxt = S_SC;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    j_r  <= j_nxt;
    r_r  <= r_nxt;
    k_r  <= k_nxt;
    jj_r <= jj_nxt;
    if (go) begin
      p_r    <= p_in;
      span_r <= span_in;
    end
  end

  assign done = (st_r == ST_IDLE);

endmodule

/* rtl/bspline_basis_derivatives_core.sv */
// B-spline basis evaluator with first and second derivatives, Q16.16.
// Requests enter on in_item when start is high and busy is low. A write
// request (operation write) stores one knot without raising busy. An
// evaluate request gives the span in index and u in value, and the block
// then sends degree+1 results on out_res, each for one cycle with out_valid
// high, basis index 0 first and last set on the final one.
// An evaluation runs every step of the basis triangle and the derivative
// coefficients through one shared adder, one two-stage multiplier and one
// radix-2 divider (48 quotient bits). The divider sets the pace, and the
// results then follow one another through the output states X_O0 to X_O3.
// A span outside the table skips the arithmetic and goes straight to its
// zero results. busy stays high until the last result has been sent.
// The user must write configuration (degree, zero threshold) on cfg_*
// only while idle; the block itself does not enforce this. cfg_ready is
// always high. Reset sets degree 3 and threshold 1 and leaves the knot
// table undefined until written. Results cannot be held off.
module bspline_basis_derivatives_core #(
  parameter int MAX_DEGREE = bbd_pkg::MAX_DEGREE_DEF,
  parameter int KNOT_DEPTH = bbd_pkg::KNOT_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bbd_pkg::in_item_t in_item,
  output logic              out_valid,
  output bbd_pkg::out_res_t out_res,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import bbd_pkg::*;

  localparam int DIM   = MAX_DEGREE + 2;
  localparam int D1_B  = DIM * DIM + 4 * DIM;
  localparam int D2_B  = D1_B + DIM;
  localparam int SCR_N = D2_B + DIM + 4;
  localparam int SAW   = $clog2(SCR_N);
  localparam int KAW   = $clog2(KNOT_DEPTH);
  localparam int PW    = $clog2(MAX_DEGREE + 1);

  localparam logic [3:0] X_IDLE = 4'd0;
  localparam logic [3:0] X_RUN  = 4'd1;
  localparam logic [3:0] X_RDB  = 4'd2;
  localparam logic [3:0] X_LATB = 4'd3;
  localparam logic [3:0] X_EXEC = 4'd4;
  localparam logic [3:0] X_WAIT = 4'd5;
  localparam logic [3:0] X_O0   = 4'd6;
  localparam logic [3:0] X_O1   = 4'd7;
  localparam logic [3:0] X_O2   = 4'd8;
  localparam logic [3:0] X_O3   = 4'd9;

  logic [1:0]         degree_r;
  logic [15:0]        thr_r;
  logic [3:0]         xst_r, xst_nxt;
  logic [PW-1:0]      i_r, p_r, p_eff;
  logic               err_r, err_now;
  logic signed [31:0] u_r, opa_r, opb_r, bv_r, fd_r;
  logic signed [31:0] knot_rd_r, scr_rd_r;
  logic               out_valid_r;
  out_res_t           out_res_r;

  logic signed [31:0] knot_mem [KNOT_DEPTH];
  logic signed [31:0] scr_mem [SCR_N];

  logic [31:0]        idx32;
  logic               accept;
  logic [SAW-1:0]     scr_raddr;
  logic               scr_we;
  logic signed [31:0] scr_wd, alu_res, unit_res;
  logic               unit_done;
  logic               seq_go, seq_adv, seq_done;
  logic               mul_start, div_start, mul_done, div_done;
  logic signed [31:0] mul_res, div_res;
  uop_t               uop;

  function automatic logic signed [31:0] pick(input logic [2:0] src,
                                              input logic signed [31:0] rd,
                                              input logic signed [31:0] kd,
                                              input logic signed [31:0] u,
                                              input logic [FACT_W-1:0] f);
    case (src)
      SRC_ONE:  return Q_ONE;
      SRC_REG:  return rd;
      SRC_KNOT: return kd;
      SRC_U:    return u;
      SRC_FACT: return 32'(f);
      default:  return 32'sd0;
    endcase
  endfunction

  assign accept  = start && !busy;
  assign idx32   = 32'(in_item.index);
  assign p_eff   = (32'(degree_r) > MAX_DEGREE) ? PW'(MAX_DEGREE) : PW'(degree_r);
  assign err_now = (idx32 + 32'd1 < 32'(p_eff)) || (idx32 + 32'(p_eff) >= KNOT_DEPTH);
  assign seq_go  = accept && in_item.operation == OPN_EVAL && !err_now;

  assign alu_res = (uop.op == OP_SUB) ? sat64(64'(opa_r) - 64'(opb_r))
                                      : sat64(64'(opa_r) + 64'(opb_r));
  assign unit_done = (uop.op == OP_DIV) ? div_done : mul_done;
  assign unit_res  = (uop.op == OP_DIV) ? div_res : mul_res;

  always_comb begin
    xst_nxt   = xst_r;
    scr_raddr = uop.a_addr[SAW-1:0];
    scr_we    = 1'b0;
    scr_wd    = alu_res;
    seq_adv   = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    case (xst_r)
      X_IDLE: begin
        if (accept && in_item.operation == OPN_EVAL) begin
          xst_nxt = err_now ? X_O0 : X_RUN;
        end
      end
      X_RUN: xst_nxt = seq_done ? X_O0 : X_RDB;
      X_RDB: begin
        scr_raddr = uop.b_addr[SAW-1:0];
        xst_nxt   = X_LATB;
      end
      X_LATB: xst_nxt = X_EXEC;
      X_EXEC: begin
        if (uop.op == OP_ADD || uop.op == OP_SUB) begin
          scr_we  = 1'b1;
          seq_adv = 1'b1;
          xst_nxt = X_RUN;
        end else begin
          div_start = uop.op == OP_DIV;
          mul_start = uop.op != OP_DIV;
          xst_nxt   = X_WAIT;
        end
      end
      X_WAIT: begin
        scr_wd = unit_res;
        if (unit_done) begin
          scr_we  = 1'b1;
          seq_adv = 1'b1;
          xst_nxt = X_RUN;
        end
      end
      // result i: value from ndu[i][p], then both derivative rows
      X_O0: begin
        scr_raddr = SAW'(32'(i_r) * DIM + 32'(p_r));
        xst_nxt   = X_O1;
      end
      X_O1: begin
        scr_raddr = SAW'(D1_B + 32'(i_r));
        xst_nxt   = X_O2;
      end
      X_O2: begin
        scr_raddr = SAW'(D2_B + 32'(i_r));
        xst_nxt   = X_O3;
      end
      X_O3: xst_nxt = (i_r == p_r) ? X_IDLE : X_O0;
      default: xst_nxt = X_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xst_r       <= X_IDLE;
      degree_r    <= 2'd3;
      thr_r       <= 16'd1;
      out_valid_r <= 1'b0;
    end else begin
      xst_r       <= xst_nxt;
      out_valid_r <= (xst_r == X_O3);
      if (cfg_valid) begin
        case (cfg_index)
          CFG_DEGREE: degree_r <= cfg_data[1:0];
          CFG_ZTHR:   thr_r    <= cfg_data;
          default: ;
        endcase
      end
    end
    if (accept && in_item.operation == OPN_WRITE && idx32 < KNOT_DEPTH) begin
      knot_mem[idx32[KAW-1:0]] <= in_item.value;
    end
    knot_rd_r <= knot_mem[uop.kaddr[KAW-1:0]];
    if (scr_we) begin
      scr_mem[uop.dst[SAW-1:0]] <= scr_wd;
    end
    scr_rd_r <= scr_mem[scr_raddr];
    if (accept) begin
      u_r   <= in_item.value;
      p_r   <= p_eff;
      err_r <= err_now;
      i_r   <= '0;
    end
    if (xst_r == X_RDB) opa_r <= pick(uop.a_src, scr_rd_r, knot_rd_r, u_r, uop.fact);
    if (xst_r == X_LATB) opb_r <= pick(uop.b_src, scr_rd_r, knot_rd_r, u_r, uop.fact);
    if (xst_r == X_O1) bv_r <= scr_rd_r;
    if (xst_r == X_O2) fd_r <= scr_rd_r;
    if (xst_r == X_O3) begin
      out_res_r.basis_index       <= 2'(i_r);
      out_res_r.basis_value       <= err_r ? 32'sd0 : bv_r;
      out_res_r.first_derivative  <= err_r ? 32'sd0 : fd_r;
      out_res_r.second_derivative <= err_r ? 32'sd0 : scr_rd_r;
      out_res_r.span_error        <= err_r;
      out_res_r.last              <= i_r == p_r;
      i_r                         <= i_r + PW'(1);
    end
  end

  bbd_seq #(
    .MAX_DEGREE(MAX_DEGREE)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (seq_go),
    .p_in    (p_eff),
    .span_in (in_item.index),
    .adv     (seq_adv),
    .uop     (uop),
    .done    (seq_done)
  );

  bbd_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .frac  (uop.op == OP_MULQ),
    .a     (opa_r),
    .b     (opb_r),
    .done  (mul_done),
    .res   (mul_res)
  );

  bbd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (opa_r),
    .den   (opb_r),
    .thr   (thr_r),
    .done  (div_done),
    .quo   (div_res)
  );

  assign busy      = xst_r != X_IDLE;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign cfg_ready = 1'b1;

endmodule

/* tb/bbd_scoreboard.sv */
`timescale 1ns / 100ps

module bbd_scoreboard (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  bbd_pkg::in_item_t in_item,
  input  logic              out_valid,
  input  bbd_pkg::out_res_t out_res,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output int                pending,
  output int                fails
);
  import bbd_pkg::*;

  localparam int MAXD = MAX_DEGREE_DEF;
  localparam int DEPTH = KNOT_DEPTH_DEF;
  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;

  logic signed [31:0] knots[DEPTH];
  logic [1:0]         cur_degree;
  logic [15:0]        cur_zthr;
  out_res_t           basis_q[$];

  assign pending = basis_q.size();

  function automatic longint clip(longint x);
    if (x > QMAX) return QMAX;
    if (x < QMIN) return QMIN;
    return x;
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint p;
    longint m;
    p = a * b;
    m = ((p < 0 ? -p : p) + 32768) >>> 16;
    return clip(p < 0 ? -m : m);
  endfunction

  function automatic longint qdiv(longint n, longint d);
    longint unsigned an;
    longint unsigned ad;
    longint q;
    ad = d < 0 ? -d : d;
    an = n < 0 ? -n : n;
    if (ad <= cur_zthr) return 0;
    q = ((an << 16) + ad / 2) / ad;
    return clip(((n < 0) != (d < 0)) ? -q : q);
  endfunction

  // triangular basis table, then derivative coefficients for each function
  function automatic void predict_basis(int span, longint u);
    longint ndu[MAXD+2][MAXD+2];
    longint lft[MAXD+2];
    longint rgt[MAXD+2];
    longint a[2][MAXD+2];
    longint ders[3][MAXD+2];
    longint saved;
    longint t;
    longint d;
    longint factor;
    int p;
    int s1;
    int s2;
    int rk;
    int pk;
    int j1;
    int j2;
    int sw;
    bit err;
    out_res_t res;
    p = cur_degree > MAXD ? MAXD : cur_degree;
    err = (span + 1 < p) || (span + p >= DEPTH);
    foreach (ders[x, y]) ders[x][y] = 0;
    if (!err) begin
      foreach (ndu[x, y]) ndu[x][y] = 0;
      foreach (a[x, y]) a[x][y] = 0;
      foreach (lft[x]) begin
        lft[x] = 0;
        rgt[x] = 0;
      end
      ndu[0][0] = 65536;
      for (int j = 1; j <= p; j++) begin
        saved = 0;
        lft[j] = clip(u - longint'(knots[span + 1 - j]));
        rgt[j] = clip(longint'(knots[span + j]) - u);
        for (int r = 0; r < j; r++) begin
          ndu[j][r] = clip(rgt[r+1] + lft[j-r]);
          t = qdiv(ndu[r][j-1], ndu[j][r]);
          ndu[r][j] = clip(saved + qmul(rgt[r+1], t));
          saved = qmul(lft[j-r], t);
        end
        ndu[j][j] = saved;
      end
      for (int j = 0; j <= p; j++) ders[0][j] = ndu[j][p];
      for (int r = 0; r <= p; r++) begin
        s1 = 0;
        s2 = 1;
        a[0][0] = 65536;
        for (int k = 1; k <= 2; k++) begin
          d = 0;
          rk = r - k;
          pk = p - k;
          if (r >= k) begin
            a[s2][0] = qdiv(a[s1][0], ndu[pk+1][rk]);
            d = qmul(a[s2][0], ndu[rk][pk]);
          end
          j1 = (rk >= -1) ? 1 : -rk;
          j2 = (r - 1 <= pk) ? (k - 1) : (p - r);
          for (int j = j1; j <= j2; j++) begin
            a[s2][j] = qdiv(clip(a[s1][j] - a[s1][j-1]), ndu[pk+1][rk+j]);
            d = clip(d + qmul(a[s2][j], ndu[rk+j][pk]));
          end
          if (r <= pk) begin
            a[s2][k] = qdiv(clip(-a[s1][k-1]), ndu[pk+1][r]);
            d = clip(d + qmul(a[s2][k], ndu[r][pk]));
          end
          ders[k][r] = d;
          sw = s1;
          s1 = s2;
          s2 = sw;
        end
      end
      factor = p;
      for (int k = 1; k <= 2; k++) begin
        for (int j = 0; j <= p; j++) ders[k][j] = clip(ders[k][j] * factor);
        factor = factor * (p - k);
      end
    end
    for (int i = 0; i <= p; i++) begin
      res.basis_index = i[1:0];
      res.basis_value = ders[0][i][31:0];
      res.first_derivative = ders[1][i][31:0];
      res.second_derivative = ders[2][i][31:0];
      res.span_error = err;
      res.last = (i == p);
      basis_q.insert(basis_q.size(), res);
    end
  endfunction

  task automatic mismatch(string what, longint want, longint got);
    $display("%0t: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
             $time, what, want, want, got, got);
    fails++;
  endtask

  always @(posedge clk) begin
    out_res_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_DEGREE) cur_degree <= cfg_data[1:0];
        else if (cfg_index == CFG_ZTHR) cur_zthr <= cfg_data;
      end
      if (start && !busy) begin
        if (in_item.operation == OPN_WRITE) knots[in_item.index] <= in_item.value;
        else predict_basis(in_item.index, longint'(in_item.value));
      end
      if (out_valid) begin
        if (basis_q.size() == 0) begin
          $display("%0t: unexpected result, got 0x%0h", $time, out_res);
          fails++;
        end else begin
          want = basis_q.pop_front();
          if (out_res.basis_index !== want.basis_index)
            mismatch("basis_index", want.basis_index, out_res.basis_index);
          if (out_res.basis_value !== want.basis_value)
            mismatch("basis_value", want.basis_value, out_res.basis_value);
          if (out_res.first_derivative !== want.first_derivative)
            mismatch("first_derivative", want.first_derivative, out_res.first_derivative);
          if (out_res.second_derivative !== want.second_derivative)
            mismatch("second_derivative", want.second_derivative, out_res.second_derivative);
          if (out_res.span_error !== want.span_error)
            mismatch("span_error", want.span_error, out_res.span_error);
          if (out_res.last !== want.last)
            mismatch("last", want.last, out_res.last);
        end
      end
    end else begin
      cur_degree <= 2'd3;
      cur_zthr <= 16'd1;
      fails = 0;
    end
  end

endmodule

/* tb/bspline_basis_derivatives_core_tb.sv */
`timescale 1ns / 100ps

module bspline_basis_derivatives_core_tb;
  import bbd_pkg::*;

  localparam int DEPTH = KNOT_DEPTH_DEF;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_res_t    out_res;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_data;
  int          pending;
  int          fails;

  bit                 knot_set[DEPTH];
  logic signed [31:0] knot_val[DEPTH];
  int                 cur_p;
  bit                 gaps_on;

  bspline_basis_derivatives_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_res(out_res), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bbd_scoreboard sb (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_res(out_res), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .fails(fails)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #50ms;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send(logic op, int idx, logic signed [31:0] val);
    if (gaps_on && $urandom_range(99) < 19) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(4)) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    in_item.operation = op;
    in_item.index = idx[5:0];
    in_item.value = val;
    do @(posedge clk); while (busy);
    if (op == OPN_WRITE) begin
      knot_set[idx] = 1'b1;
      knot_val[idx] = val;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    wait (pending == 0 && !busy);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] data);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == CFG_DEGREE) cur_p = data[1:0];
  endtask

  // any knot of the window still unwritten gets a random value first
  task automatic fill_window(int span);
    if (cur_p == 0 || span + 1 < cur_p || span + cur_p >= DEPTH) return;
    for (int i = span + 1 - cur_p; i <= span + cur_p; i++)
      if (!knot_set[i]) send(OPN_WRITE, i, $urandom);
  endtask

  task automatic evaluate(int span, logic signed [31:0] u);
    fill_window(span);
    send(OPN_EVAL, span, u);
  endtask

  // non-decreasing knots around a legal span, then one to three parameters, mostly inside it
  task automatic knot_run();
    int span;
    int lo;
    int hi;
    longint k;
    longint w;
    span = $urandom_range(DEPTH - 1 - (cur_p == 0 ? 1 : cur_p), cur_p == 0 ? 0 : cur_p - 1);
    lo = span + 1 - cur_p;
    hi = span + cur_p;
    if (cur_p == 0) begin
      lo = span;
      hi = span + 1;
    end
    k = longint'($urandom_range(400)) * 65536 - 200 * 65536 + $urandom_range(65535);
    for (int i = lo; i <= hi; i++) begin
      send(OPN_WRITE, i, k[31:0]);
      if ($urandom_range(4) == 0) k = k + $urandom_range(3);
      else k = k + $urandom_range(3 * 65536, 1);
    end
    repeat ($urandom_range(3, 1)) begin
      w = longint'(knot_val[span + 1]) - longint'(knot_val[span]);
      k = longint'(knot_val[span]) + (w > 0 ? longint'($urandom) % (w + 1) : 0);
      if ($urandom_range(9) == 0) k = k + $urandom_range(2 * 65536) - 65536;
      evaluate(span, k[31:0]);
    end
  endtask

  task automatic noise_item();
    case ($urandom_range(3))
      0: send(OPN_WRITE, $urandom_range(DEPTH - 1), $urandom);
      1: evaluate($urandom_range(DEPTH - 1), $urandom);
      default: evaluate($urandom_range(DEPTH - 1),
                        $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000);
    endcase
  endtask

  initial begin
    int zt[4];
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_DEGREE;
    cfg_data = '0;
    cur_p = 3;
    gaps_on = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // uniform knots 0..9, degree 3 after reset
    for (int i = 0; i < 10; i++) send(OPN_WRITE, i, i * 65536);
    send(OPN_EVAL, 4, 32'sh0004_8000);
    send(OPN_EVAL, 0, 32'sh0000_8000);
    send(OPN_EVAL, 63, 32'sh0001_0000);
    send(OPN_EVAL, 5, 32'sh7fff_ffff);
    send(OPN_EVAL, 5, 32'sh8000_0000);
    send(OPN_WRITE, 63, 32'sh8000_0000);
    send(OPN_WRITE, 62, 32'sh7fff_ffff);
    send(OPN_WRITE, 6, 32'sh0005_0000);
    send(OPN_EVAL, 5, 32'sh0005_0000);
    write_reg(CFG_DEGREE, 16'd0);
    send(OPN_EVAL, 63, 32'sh1234_5678);
    write_reg(CFG_DEGREE, 16'd1);
    send(OPN_EVAL, 62, 32'sh0000_0000);
    send(OPN_EVAL, 2, 32'sh0002_4000);
    write_reg(CFG_DEGREE, 16'd2);
    write_reg(CFG_ZTHR, 16'hffff);
    send(OPN_EVAL, 3, 32'sh0003_8000);
    write_reg(CFG_ZTHR, 16'd0);
    send(OPN_EVAL, 6, 32'sh0005_0000);

    zt[0] = 0;
    zt[1] = 1;
    zt[2] = 65535;
    zt[3] = $urandom_range(65535);
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_DEGREE, ph < 4 ? 16'd3 : 16'($urandom_range(3)));
      write_reg(CFG_ZTHR, 16'(zt[ph % 4]));
      gaps_on = (ph != 2);
      for (int n = 0; n < 4; n++) knot_run();
      repeat (6) noise_item();
      if (ph == 5) drain();
    end
    drain();
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
